/* rtl/discovery_entity_tracker_core_assert.svh */
// Assertion macros for the entity tracker checker.
// Uses the clk and rst names of the module that expands them.
`ifndef DISCOVERY_ENTITY_TRACKER_CORE_ASSERT_SVH
`define DISCOVERY_ENTITY_TRACKER_CORE_ASSERT_SVH

// Checked only outside reset.
`define DET_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define DET_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/det_pkg.sv */
// Shared types and constants for the discovery entity tracker.
// No dependencies.
package det_pkg;

  localparam int MAX_ENTITIES_DEF = 16;
  localparam int MAX_RESULTS      = 16;
  localparam int MS_PER_S         = 1000;
  localparam int LIFE_MS_W        = 18;

  localparam logic [1:0] ST_UNKNOWN   = 2'd0;
  localparam logic [1:0] ST_AVAILABLE = 2'd1;
  localparam logic [1:0] ST_DEPARTING = 2'd2;
  localparam logic [1:0] ST_TIMED_OUT = 2'd3;

  localparam logic [2:0] CAUSE_AVAILABLE = 3'd0;
  localparam logic [2:0] CAUSE_BACKWARDS = 3'd1;
  localparam logic [2:0] CAUSE_DEPARTING = 3'd2;
  localparam logic [2:0] CAUSE_TIMEOUT   = 3'd3;
  localparam logic [2:0] CAUSE_FULL      = 3'd4;

  localparam logic [3:0] MSG_AVAILABLE = 4'd0;
  localparam logic [3:0] MSG_DEPARTING = 4'd1;

  typedef struct packed {
    logic [63:0]          id;
    logic [1:0]           st;
    logic [31:0]          index;
    logic [LIFE_MS_W-1:0] life_ms;
    logic [31:0]          seen_ms;
  } entry_t;

  typedef struct packed {
    logic [63:0] entity;
    logic [1:0]  from_st;
    logic [1:0]  to_st;
    logic [2:0]  cause;
  } res_t;

endpackage

/* rtl/discovery_entity_tracker_core.sv */
// Discovery entity tracker top level: control, slot scan and result queue.
// Depends on det_pkg and det_table.
//
//  channel  | valid       | stall       | payload
//  ---------+-------------+-------------+------------------------------------------
//  item in  | item_valid  | item_stall  | func, msg_kind, source_id, ...
//  event out| event_valid | event_stall | event_entity, from_state, to_state, ...
//
// A tick or an available or departing message scans every slot: the table is read
// one slot per cycle through its single read port while the output is not stalled.
// Other message types are taken without leaving idle and give no result.
// Reset clears the in-use bits at once; no clearing pass.
// A stalled output holds the scan; the input is stalled until the item is done.
module discovery_entity_tracker_core #(
  parameter int MAX_ENTITIES = det_pkg::MAX_ENTITIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        func,
  input  logic [3:0]  msg_kind,
  input  logic [63:0] source_id,
  input  logic [31:0] announce_count,
  input  logic [7:0]  valid_time_s,
  input  logic [31:0] timestamp_ms,
  output logic        event_valid,
  input  logic        event_stall,
  output logic [63:0] event_entity,
  output logic [1:0]  from_state,
  output logic [1:0]  to_state,
  output logic [2:0]  cause,
  output logic        last
);
  import det_pkg::*;

  localparam int SW    = (MAX_ENTITIES > 1) ? $clog2(MAX_ENTITIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTITIES + 1);
  localparam int RES_W = $clog2(MAX_RESULTS + 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DECIDE = 4'b0100,
    S_FINISH = 4'b1000
  } fsm_t;

  fsm_t state, state_next;

  logic                 is_tick, req_depart;
  logic [63:0]          req_id;
  logic [31:0]          req_idx, req_ts;
  logic [7:0]           req_life;

  logic [CNT_W-1:0]     issue_cnt;
  logic                 rd_vld;
  logic [SW-1:0]        rd_slot;
  logic [RES_W-1:0]     n;
  logic                 found, have_free;
  logic [SW-1:0]        m_slot, f_slot;
  logic [1:0]           m_state;
  logic [31:0]          m_index;
  logic [LIFE_MS_W-1:0] m_life_ms;
  logic [MAX_ENTITIES-1:0] used;

  logic                 hold_vld;
  res_t                 hold;

  entry_t               rd;
  logic                 wr_en;
  logic [SW-1:0]        wr_addr;
  entry_t               wr_data;

  logic                 accept, out_free, issue, eval, scan_end;
  logic                 rd_used, expire, tick_hit, match, free_hit;
  logic [32:0]          limit;
  res_t                 tick_res;
  logic                 push_mid, push_end;

  logic                 d_full, d_emit;
  logic [SW-1:0]        d_slot;
  logic [1:0]           d_prev;
  logic [31:0]          d_idx_old;
  logic [LIFE_MS_W-1:0] d_life_old, req_life_ms;
  res_t                 d_res;
  entry_t               d_entry;

  det_table #(.DEPTH(MAX_ENTITIES), .AW(SW)) u_table (
    .clk     (clk),
    .rd_en   (issue),
    .rd_addr (issue_cnt[SW-1:0]),
    .rd_data (rd),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && (state == S_IDLE);
  assign out_free   = !event_valid || !event_stall;
  assign issue      = (state == S_SCAN) && (issue_cnt < CNT_W'(MAX_ENTITIES)) &&
                      (!rd_vld || out_free);
  assign eval       = (state == S_SCAN) && rd_vld && out_free;
  assign scan_end   = (state == S_SCAN) && (issue_cnt == CNT_W'(MAX_ENTITIES)) &&
                      (!rd_vld || eval);

  assign rd_used  = used[rd_slot];
  assign limit    = {1'b0, rd.seen_ms} + 33'(rd.life_ms);
  assign expire   = rd_used && (rd.st == ST_AVAILABLE) && (rd.life_ms != '0) &&
                    ({1'b0, req_ts} > limit) && (n < RES_W'(MAX_RESULTS));
  assign tick_hit = eval && is_tick && expire;
  assign match    = eval && !is_tick && rd_used && (rd.id == req_id) && !found;
  assign free_hit = eval && !is_tick && !rd_used && !have_free;

  assign tick_res = '{entity: rd.id, from_st: ST_AVAILABLE, to_st: ST_TIMED_OUT,
                      cause: CAUSE_TIMEOUT};

  assign push_mid = tick_hit && hold_vld;
  assign push_end = (state == S_FINISH) && hold_vld && out_free;

  assign req_life_ms = LIFE_MS_W'(req_life) * LIFE_MS_W'(MS_PER_S);

  always_comb begin
    d_full     = !found && !have_free;
    d_slot     = found ? m_slot : f_slot;
    d_prev     = found ? m_state : ST_UNKNOWN;
    d_idx_old  = found ? m_index : '0;
    d_life_old = found ? m_life_ms : '0;
    d_emit     = 1'b0;
    d_res      = '{entity: req_id, from_st: d_prev, to_st: ST_AVAILABLE,
                   cause: CAUSE_AVAILABLE};
    if (req_depart) begin
      d_entry = '{id: req_id, st: ST_DEPARTING, index: d_idx_old,
                  life_ms: d_life_old, seen_ms: req_ts};
      d_emit  = (d_prev != ST_DEPARTING);
      d_res.to_st = ST_DEPARTING;
      d_res.cause = CAUSE_DEPARTING;
    end else begin
      d_entry = '{id: req_id, st: ST_AVAILABLE, index: req_idx,
                  life_ms: req_life_ms, seen_ms: req_ts};
      if (found && (d_prev == ST_AVAILABLE) && (req_idx < d_idx_old)) begin
        d_emit        = 1'b1;
        d_res.from_st = ST_AVAILABLE;
        d_res.cause   = CAUSE_BACKWARDS;
      end else begin
        d_emit = (d_prev != ST_AVAILABLE);
      end
    end
    if (d_full) begin
      d_emit = 1'b1;
      d_res  = '{entity: req_id, from_st: ST_UNKNOWN, to_st: ST_UNKNOWN,
                 cause: CAUSE_FULL};
    end
  end

  always_comb begin
    wr_en   = tick_hit || ((state == S_DECIDE) && !d_full);
    wr_addr = tick_hit ? rd_slot : d_slot;
    wr_data = d_entry;
    if (tick_hit) begin
      wr_data    = rd;
      wr_data.st = ST_TIMED_OUT;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && (func || (msg_kind == MSG_AVAILABLE) ||
                       (msg_kind == MSG_DEPARTING))) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          state_next = is_tick ? S_FINISH : S_DECIDE;
        end
      end
      S_DECIDE: state_next = S_FINISH;
      S_FINISH: begin
        if (!hold_vld || out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      used        <= '0;
      rd_vld      <= 1'b0;
      hold_vld    <= 1'b0;
      event_valid <= 1'b0;
      issue_cnt   <= '0;
      n           <= '0;
      found       <= 1'b0;
      have_free   <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        issue_cnt <= '0;
        rd_vld    <= 1'b0;
        n         <= '0;
        found     <= 1'b0;
        have_free <= 1'b0;
      end else begin
        if (issue) begin
          issue_cnt <= issue_cnt + 1'b1;
          rd_vld    <= 1'b1;
        end else if (eval) begin
          rd_vld <= 1'b0;
        end
        if (tick_hit) begin
          n <= n + 1'b1;
        end
        if (match) begin
          found <= 1'b1;
        end
        if (free_hit) begin
          have_free <= 1'b1;
        end
      end
      if ((state == S_DECIDE) && !d_full) begin
        used[d_slot] <= 1'b1;
      end
      if (tick_hit || ((state == S_DECIDE) && d_emit)) begin
        hold_vld <= 1'b1;
      end else if (push_end) begin
        hold_vld <= 1'b0;
      end
      if (push_mid || push_end) begin
        event_valid <= 1'b1;
      end else if (!event_stall) begin
        event_valid <= 1'b0;
      end
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      is_tick    <= func;
      req_depart <= (msg_kind == MSG_DEPARTING);
      req_id     <= source_id;
      req_idx    <= announce_count;
      req_life   <= valid_time_s;
      req_ts     <= timestamp_ms;
    end
    if (issue) begin
      rd_slot <= issue_cnt[SW-1:0];
    end
    if (match) begin
      m_slot    <= rd_slot;
      m_state   <= rd.st;
      m_index   <= rd.index;
      m_life_ms <= rd.life_ms;
    end
    if (free_hit) begin
      f_slot <= rd_slot;
    end
    if (tick_hit) begin
      hold <= tick_res;
    end else if ((state == S_DECIDE) && d_emit) begin
      hold <= d_res;
    end
    if (push_mid || push_end) begin
      event_entity <= hold.entity;
      from_state   <= hold.from_st;
      to_state     <= hold.to_st;
      cause        <= hold.cause;
      last         <= push_end;
    end
  end

endmodule

/* rtl/det_table.sv */
// Entity table storage: one synchronous memory, one read and one write port.
// Depends on det_pkg (entry_t).
module det_table #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic            clk,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output det_pkg::entry_t rd_data,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  det_pkg::entry_t wr_data
);
  import det_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/det_checker.sv */
// Port-level checks for the discovery entity tracker, bound to the top level.
// Depends on det_pkg and discovery_entity_tracker_core_assert.svh.
`include "discovery_entity_tracker_core_assert.svh"

module det_checker (
  input logic        clk,
  input logic        rst,
  input logic        item_valid,
  input logic        item_stall,
  input logic        func,
  input logic [3:0]  msg_kind,
  input logic        event_valid,
  input logic        event_stall,
  input logic [63:0] event_entity,
  input logic [1:0]  from_state,
  input logic [1:0]  to_state,
  input logic [2:0]  cause,
  input logic        last
);
  import det_pkg::*;

  localparam logic [3:0] PAIR_FULL    = {ST_UNKNOWN, ST_UNKNOWN};
  localparam logic [3:0] PAIR_TIMEOUT = {ST_AVAILABLE, ST_TIMED_OUT};

  logic        ev_held, ev_full, ev_timeout, took_tracked;
  logic [3:0]  st_pair;
  logic [71:0] ev_word;

  assign ev_held      = event_valid && event_stall;
  assign ev_full      = event_valid && (cause == CAUSE_FULL);
  assign ev_timeout   = event_valid && (cause == CAUSE_TIMEOUT);
  assign took_tracked = item_valid && !item_stall &&
                        (func || (msg_kind == MSG_AVAILABLE) || (msg_kind == MSG_DEPARTING));
  assign st_pair      = {from_state, to_state};
  assign ev_word      = {event_entity, from_state, to_state, cause, last};

  `DET_ASSERT(a_out_hold, ev_held |=> event_valid && $stable(ev_word), "stalled event changed")
  `DET_ASSERT(a_full_shape, ev_full |-> (st_pair == PAIR_FULL) && last, "bad table full event")
  `DET_ASSERT(a_timeout_shape, ev_timeout |-> (st_pair == PAIR_TIMEOUT), "bad timeout event")
  `DET_ASSERT(a_busy_after_take, took_tracked |=> item_stall, "tracked item not held busy")
  `DET_ASSERT_ALWAYS(a_reset_quiet, rst |=> !event_valid, "event valid after reset")

endmodule

bind discovery_entity_tracker_core det_checker u_det_checker (.*);

/* dv/tb.sv */
// Self-checking testbench for discovery_entity_tracker_core: directed and random
// items, a scoreboard class predicts the entity table events.
// Depends on det_pkg and the RTL of the tracker core.

localparam bit FUNC_MESSAGE = 1'b0;
localparam bit FUNC_TICK = 1'b1;
localparam logic [3:0] MSG_DISCOVER = 4'd2;

typedef struct {
  logic [63:0] entity;
  logic [1:0]  from_st;
  logic [1:0]  to_st;
  logic [2:0]  cause;
  logic        last;
} state_event_t;

class tracker_scoreboard;
  bit          slot_used    [det_pkg::MAX_ENTITIES_DEF];
  logic [63:0] slot_id      [det_pkg::MAX_ENTITIES_DEF];
  logic [1:0]  slot_state   [det_pkg::MAX_ENTITIES_DEF];
  logic [31:0] slot_index   [det_pkg::MAX_ENTITIES_DEF];
  logic [7:0]  slot_life_s  [det_pkg::MAX_ENTITIES_DEF];
  logic [31:0] slot_seen_ms [det_pkg::MAX_ENTITIES_DEF];
  state_event_t pending_events[$];
  int errors;

  function int outstanding();
    return pending_events.size();
  endfunction

  function void add_event(logic [63:0] id, logic [1:0] from_st, logic [1:0] to_st,
                          logic [2:0] why);
    state_event_t ev;
    ev.entity = id;
    ev.from_st = from_st;
    ev.to_st = to_st;
    ev.cause = why;
    ev.last = 1'b0;
    pending_events.insert(pending_events.size(), ev);
  endfunction

  // Updates the table copy for one accepted item and queues its events.
  function void apply_item(bit f, logic [3:0] msg, logic [63:0] id, logic [31:0] ai,
                           logic [7:0] vt, logic [31:0] tms);
    int first;
    int slot;
    bit fresh;
    logic [1:0] prev;
    logic [63:0] expiry;
    first = pending_events.size();
    if (f == FUNC_TICK) begin
      for (int i = 0; i < det_pkg::MAX_ENTITIES_DEF; i++) begin
        if (pending_events.size() - first >= det_pkg::MAX_RESULTS) break;
        if (slot_used[i] && slot_state[i] == det_pkg::ST_AVAILABLE &&
            slot_life_s[i] != 8'd0) begin
          expiry = {32'd0, slot_seen_ms[i]} + {56'd0, slot_life_s[i]} * 64'd1000;
          if ({32'd0, tms} > expiry) begin
            slot_state[i] = det_pkg::ST_TIMED_OUT;
            add_event(slot_id[i], det_pkg::ST_AVAILABLE, det_pkg::ST_TIMED_OUT,
                      det_pkg::CAUSE_TIMEOUT);
          end
        end
      end
    end else if (msg == det_pkg::MSG_AVAILABLE || msg == det_pkg::MSG_DEPARTING) begin
      slot = -1;
      fresh = 1'b0;
      for (int i = 0; i < det_pkg::MAX_ENTITIES_DEF; i++)
        if (slot_used[i] && slot_id[i] == id) slot = i;
      if (slot < 0) begin
        for (int i = 0; i < det_pkg::MAX_ENTITIES_DEF; i++) begin
          if (!slot_used[i] && slot < 0) begin
            slot = i;
            fresh = 1'b1;
          end
        end
      end
      if (slot >= 0 && fresh) begin
        slot_used[slot] = 1'b1;
        slot_id[slot] = id;
        slot_state[slot] = det_pkg::ST_UNKNOWN;
        slot_index[slot] = '0;
        slot_life_s[slot] = '0;
        slot_seen_ms[slot] = '0;
      end
      if (slot < 0) begin
        add_event(id, det_pkg::ST_UNKNOWN, det_pkg::ST_UNKNOWN, det_pkg::CAUSE_FULL);
      end else if (msg == det_pkg::MSG_AVAILABLE) begin
        prev = slot_state[slot];
        if (!fresh && prev == det_pkg::ST_AVAILABLE && ai < slot_index[slot])
          add_event(id, det_pkg::ST_AVAILABLE, det_pkg::ST_AVAILABLE,
                    det_pkg::CAUSE_BACKWARDS);
        else if (prev != det_pkg::ST_AVAILABLE)
          add_event(id, prev, det_pkg::ST_AVAILABLE, det_pkg::CAUSE_AVAILABLE);
        slot_state[slot] = det_pkg::ST_AVAILABLE;
        slot_index[slot] = ai;
        slot_life_s[slot] = vt;
        slot_seen_ms[slot] = tms;
      end else begin
        prev = slot_state[slot];
        slot_seen_ms[slot] = tms;
        if (prev != det_pkg::ST_DEPARTING) begin
          slot_state[slot] = det_pkg::ST_DEPARTING;
          add_event(id, prev, det_pkg::ST_DEPARTING, det_pkg::CAUSE_DEPARTING);
        end
      end
    end
    if (pending_events.size() > first)
      pending_events[pending_events.size() - 1].last = 1'b1;
  endfunction

  function void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  function void check_event(logic [63:0] ent, logic [1:0] fs, logic [1:0] ts, logic [2:0] why,
                            logic fin);
    state_event_t want;
    if (pending_events.size() == 0) begin
      $display("%0t: unexpected event: expected none, actual entity %h from %0d to %0d %s %0d",
               $time, ent, fs, ts, "cause", why);
      errors++;
      return;
    end
    want = pending_events.pop_front();
    check_field("event_entity", want.entity, ent);
    check_field("from_state", want.from_st, fs);
    check_field("to_state", want.to_st, ts);
    check_field("cause", want.cause, why);
    check_field("last", want.last, fin);
  endfunction
endclass

module tb;
  import det_pkg::*;

  localparam int SLOTS = MAX_ENTITIES_DEF;
  localparam int RANDOM_ITEMS = 352;
  localparam int LONG_HOLD = 300;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  logic        clk;
  logic        rst;
  logic        item_valid;
  logic        item_stall;
  logic        func;
  logic [3:0]  msg_kind;
  logic [63:0] source_id;
  logic [31:0] announce_count;
  logic [7:0]  valid_time_s;
  logic [31:0] timestamp_ms;
  logic        event_valid;
  logic        event_stall;
  logic [63:0] event_entity;
  logic [1:0]  from_state;
  logic [1:0]  to_state;
  logic [2:0]  cause;
  logic        last;

  tracker_scoreboard sb = new();
  int source_quiet;
  int sink_quiet;
  bit long_hold_req;
  int unsigned cycles;

  discovery_entity_tracker_core #(.MAX_ENTITIES(SLOTS)) uut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic offer(bit f, logic [3:0] msg, logic [63:0] id, logic [31:0] ai,
                       logic [7:0] vt, logic [31:0] tms);
    int gap;
    if (source_quiet > 0) begin
      gap = 0;
      source_quiet--;
    end else begin
      gap = $urandom_range(0, 14);
    end
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    func <= f;
    msg_kind <= msg;
    source_id <= id;
    announce_count <= ai;
    valid_time_s <= vt;
    timestamp_ms <= tms;
    do @(posedge clk); while (item_stall !== 1'b0);
    sb.apply_item(f, msg, id, ai, vt, tms);
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  initial begin : event_sink
    int hold;
    event_stall <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (long_hold_req) begin
        hold = LONG_HOLD;
        long_hold_req = 1'b0;
      end else if (sink_quiet > 0) begin
        hold = 0;
        sink_quiet--;
      end else begin
        hold = $urandom_range(0, 14);
        if ($urandom_range(0, 49) == 0) sink_quiet = 30;
      end
      if (hold > 0) begin
        event_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      event_stall <= 1'b0;
      do @(posedge clk); while (event_valid !== 1'b1);
      sb.check_event(event_entity, from_state, to_state, cause, last);
    end
  end

  initial begin : stimulus
    logic [63:0] pool [SLOTS];
    logic [31:0] now_ms;
    logic [3:0]  kind;
    logic [63:0] id;
    int r;
    int accepted_items;
    rst <= 1'b1;
    item_valid <= 1'b0;
    func <= FUNC_MESSAGE;
    msg_kind <= MSG_AVAILABLE;
    source_id <= '0;
    announce_count <= '0;
    valid_time_s <= '0;
    timestamp_ms <= '0;
    pool[0] = '0;
    pool[1] = '1;
    for (int i = 2; i < SLOTS; i++) pool[i] = {$urandom, $urandom};
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // fill the table: never-expiring, max fields, new entity via departing
    offer(FUNC_MESSAGE, MSG_AVAILABLE, pool[0], 32'd0, 8'd0, 32'd0);
    offer(FUNC_MESSAGE, MSG_AVAILABLE, pool[1], '1, 8'd255, '1);
    offer(FUNC_MESSAGE, MSG_DEPARTING, pool[2], 32'd7, 8'd3, 32'd100);
    for (int i = 3; i < SLOTS - 1; i++)
      offer(FUNC_MESSAGE, MSG_AVAILABLE, pool[i], 32'(i), 8'd1, 32'd1000);
    offer(FUNC_MESSAGE, MSG_AVAILABLE, pool[SLOTS-1], 32'd5, 8'd2, 32'd1000);
    // table full, ignored types, index backwards, repeats
    offer(FUNC_MESSAGE, MSG_AVAILABLE, {$urandom, $urandom}, 32'd1, 8'd1, 32'd1000);
    offer(FUNC_MESSAGE, MSG_DEPARTING, {$urandom, $urandom}, 32'd1, 8'd1, 32'd1000);
    offer(FUNC_MESSAGE, MSG_DISCOVER, pool[3], 32'd0, 8'd1, 32'd1000);
    offer(FUNC_MESSAGE, 4'd15, pool[3], 32'd0, 8'd1, 32'd1000);
    offer(FUNC_MESSAGE, MSG_AVAILABLE, pool[3], 32'd1, 8'd1, 32'd1000);
    offer(FUNC_MESSAGE, MSG_AVAILABLE, pool[3], 32'd1, 8'd1, 32'd1000);
    offer(FUNC_MESSAGE, MSG_DEPARTING, pool[2], 32'd0, 8'd0, 32'd1000);
    offer(FUNC_MESSAGE, MSG_DEPARTING, pool[4], 32'd0, 8'd0, 32'd1000);
    // expiry boundary, mass timeout, revival, time going backwards
    offer(FUNC_TICK, 4'd0, '0, '0, '0, 32'd2000);
    offer(FUNC_TICK, 4'hf, '1, '1, '1, 32'd2001);
    offer(FUNC_MESSAGE, MSG_AVAILABLE, pool[5], 32'd9, 8'd1, 32'd2500);
    offer(FUNC_TICK, 4'd0, '0, '0, '0, 32'd0);
    wait_drained();

    now_ms = 32'd5000;
    accepted_items = 0;
    while (accepted_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 39) == 0) source_quiet = 20;
      r = $urandom_range(0, 99);
      if (r < 22) begin
        now_ms += ($urandom_range(0, 6) == 0) ? $urandom_range(0, 400000)
                                              : $urandom_range(0, 2500);
        offer(FUNC_TICK, 4'($urandom), {$urandom, $urandom}, $urandom, 8'($urandom),
              ($urandom_range(0, 19) == 0) ? $urandom : now_ms);
      end else begin
        kind = (r < 62) ? MSG_AVAILABLE : (r < 80) ? MSG_DEPARTING :
               (r < 90) ? MSG_DISCOVER : 4'($urandom_range(3, 15));
        id = ($urandom_range(0, 7) == 0) ? {$urandom, $urandom}
                                         : pool[$urandom_range(0, SLOTS-1)];
        offer(FUNC_MESSAGE, kind, id,
              ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 31),
              ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4)),
              ($urandom_range(0, 19) == 0) ? $urandom : now_ms + $urandom_range(0, 500));
      end
      accepted_items++;
      if (accepted_items == 120) wait_drained();
      if (accepted_items == 240) long_hold_req = 1'b1;
    end

    wait_drained();
    repeat (2 * SLOTS + 8) @(posedge clk);
    if (sb.errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end
endmodule
